/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// ante holding at an edge requires cons at the same edge
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// cond must never be seen at a clock edge
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* rtl/rtt_pkg.sv */
`default_nettype none
package rtt_pkg;

	localparam int unsigned PRICE_W   = 32;
	localparam int unsigned DIFF_W    = 33;
	localparam int unsigned RSI_W     = 14;
	localparam int unsigned POS_W     = 17;
	localparam int unsigned CASH_W    = 64;
	localparam int unsigned WLEN_W    = 9;
	localparam int unsigned LIMIT_W   = 16;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned PCT_SCALE = 100;
	localparam logic [RSI_W-1:0] RSI_FULL = RSI_W'(PCT_SCALE * PCT_SCALE);

	// register reset values
	localparam logic [WLEN_W-1:0]  WINDOW_RESET     = WLEN_W'(14);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET      = LIMIT_W'(5);
	localparam logic [RSI_W-1:0]   OVERSOLD_RESET   = RSI_W'(3000);
	localparam logic [RSI_W-1:0]   OVERBOUGHT_RESET = RSI_W'(7000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW     = 2'd0,
		REG_LIMIT      = 2'd1,
		REG_OVERSOLD   = 2'd2,
		REG_OVERBOUGHT = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ORDER_NONE = 2'd0,
		ORDER_BUY  = 2'd1,
		ORDER_SELL = 2'd2,
		ORDER_BOTH = 2'd3
	} order_kind_t;

	// what the front decided about an item
	typedef enum logic [1:0] {
		ITEM_FIRST,	// first price since reset or a window restart, its difference is not used
		ITEM_PRIME,	// difference goes into the window, no decision
		ITEM_TRADE	// full window, decide and retire the oldest difference
	} item_class_t;

	typedef struct packed {
		item_class_t               cls;
		logic [PRICE_W-1:0]        price;
		logic signed [DIFF_W-1:0]  diff;
	} queue_entry_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic [RSI_W-1:0]   oversold;
		logic [RSI_W-1:0]   overbought;
	} trade_cfg_t;

endpackage
`default_nettype wire

/* rtl/rtt_channels.sv */
`default_nettype none
interface rtt_price_if;
	import rtt_pkg::*;

	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] price_cents;

	modport source (output valid, output price_cents, input ready);
	modport sink   (input valid, input price_cents, output ready);
endinterface

interface rtt_result_if;
	import rtt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     active;
	logic [RSI_W-1:0]         rsi_hundredths;
	logic [1:0]               order_kind;
	logic signed [POS_W-1:0]  net_position;
	logic signed [CASH_W-1:0] cash_cents;
	logic signed [CASH_W-1:0] marked_value;

	modport source (output valid, output active, output rsi_hundredths, output order_kind,
		output net_position, output cash_cents, output marked_value, input ready);
	modport sink (input valid, input active, input rsi_hundredths, input order_kind,
		input net_position, input cash_cents, input marked_value, output ready);
endinterface
`default_nettype wire

/* rtl/rtt_front.sv */
`default_nettype none
module rtt_front #(
	parameter int unsigned WINDOW_MAX = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	rtt_price_if.sink                                prices,
	input  wire logic                                restart,
	input  wire logic [$clog2(WINDOW_MAX + 1)-1:0]   win,
	output rtt_pkg::queue_entry_t                    push_entry,
	output logic                                     push_valid,
	input  wire logic                                push_ready
);
	import rtt_pkg::*;

	localparam int unsigned SEEN_W = $clog2(WINDOW_MAX + 1);

	logic [PRICE_W-1:0] last_price_q;
	logic [SEEN_W-1:0]  seen_q;
	logic               take;

	assign prices.ready = push_ready;
	assign push_valid   = prices.valid;
	assign take         = prices.valid && push_ready;

	always_comb begin
		push_entry.price = prices.price_cents;
		push_entry.diff  = $signed({1'b0, prices.price_cents}) - $signed({1'b0, last_price_q});
		priority if (seen_q == '0) begin
			push_entry.cls = ITEM_FIRST;
		end else if (seen_q < win) begin
			push_entry.cls = ITEM_PRIME;
		end else begin
			push_entry.cls = ITEM_TRADE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_price_q <= '0;
			seen_q       <= '0;
		end else begin
			// window restart keeps the last price
			priority if (restart) begin
				seen_q <= '0;
			end else if (take) begin
				last_price_q <= prices.price_cents;
				if (push_entry.cls != ITEM_TRADE) begin
					seen_q <= seen_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/rtt_queue.sv */
`default_nettype none
module rtt_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire rtt_pkg::queue_entry_t push_entry,
	output logic               pop_valid,
	input  wire logic          pop_ready,
	output rtt_pkg::queue_entry_t pop_entry
);
	import rtt_pkg::*;

	localparam int unsigned DEPTH = 2;

	queue_entry_t                 slot_q [DEPTH];
	logic [$clog2(DEPTH)-1:0]     wr_ptr_q;
	logic [$clog2(DEPTH)-1:0]     rd_ptr_q;
	logic [$clog2(DEPTH + 1)-1:0] count_q;
	logic                         push;
	logic                         pop;

	assign push_ready = (count_q != DEPTH[$clog2(DEPTH + 1)-1:0]);
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/rtt_back.sv */
`default_nettype none
module rtt_back #(
	parameter int unsigned WINDOW_MAX = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                restart,
	input  wire logic [$clog2(WINDOW_MAX + 1)-1:0]   win,
	input  wire rtt_pkg::trade_cfg_t                 cfg,
	input  wire logic                                pop_valid,
	output logic                                     pop_ready,
	input  wire rtt_pkg::queue_entry_t               pop_entry,
	rtt_result_if.source                             results
);
	import rtt_pkg::*;

	localparam int unsigned AW     = $clog2(WINDOW_MAX);
	localparam int unsigned WW     = $clog2(WINDOW_MAX + 1);
	localparam int unsigned SUM_W  = PRICE_W + AW;
	localparam int unsigned NUM_W  = SUM_W + RSI_W;
	localparam int unsigned DEN_W  = SUM_W + 1;
	localparam int unsigned STEP_W = $clog2(RSI_W);
	localparam int unsigned PROD_W = POS_W + PRICE_W + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_PUSH, S_SCALE, S_DIVINIT, S_DIV, S_BUY, S_SELL, S_MARK, S_SAT, S_OUT
	} state_t;

	function automatic logic [CASH_W-1:0] sat_cash(input logic [CASH_W:0] wide);
		logic [CASH_W-1:0] res;
		if (wide[CASH_W] != wide[CASH_W-1]) begin
			res = wide[CASH_W] ? {1'b1, {(CASH_W - 1){1'b0}}} : {1'b0, {(CASH_W - 1){1'b1}}};
		end else begin
			res = wide[CASH_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [PRICE_W-1:0] mag(input logic signed [DIFF_W-1:0] d);
		logic signed [DIFF_W-1:0] pos;
		pos = d[DIFF_W-1] ? -d : d;
		return pos[PRICE_W-1:0];
	endfunction

	state_t                   state_q;
	queue_entry_t             item_q;
	logic [AW-1:0]            slot_q;
	logic [SUM_W-1:0]         gain_q;
	logic [SUM_W-1:0]         loss_q;
	logic signed [POS_W-1:0]  pos_q;
	logic [CASH_W-1:0]        cash_q;
	logic [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]         den_q;
	logic [DEN_W-1:0]         rem_q;
	logic [RSI_W-1:0]         low_q;
	logic [RSI_W-1:0]         quo_q;
	logic [STEP_W-1:0]        step_q;
	logic [RSI_W-1:0]         rsi_q;
	order_kind_t              kind_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [CASH_W-1:0]        mark_q;
	logic signed [DIFF_W-1:0] old_q;
	logic                     out_valid_q;
	logic                     out_active_q;
	logic [RSI_W-1:0]         out_rsi_q;
	order_kind_t              out_kind_q;
	logic signed [POS_W-1:0]  out_pos_q;
	logic [CASH_W-1:0]        out_cash_q;
	logic [CASH_W-1:0]        out_mark_q;

	logic signed [DIFF_W-1:0] ring_mem [WINDOW_MAX];

	logic [DEN_W:0]           trial;
	logic                     ge;
	logic [WW:0]              old_wide;
	logic [AW-1:0]            old_addr;
	logic signed [POS_W-1:0]  lim;
	logic signed [POS_W-1:0]  neg_lim;
	logic [RSI_W-1:0]         rsi_v;
	logic                     buy_ok;
	logic                     sell_ok;
	logic [CASH_W:0]          cash_ext;
	logic [CASH_W:0]          price_ext;
	logic [CASH_W:0]          prod_ext;
	logic [PRICE_W-1:0]       new_mag;
	logic [PRICE_W-1:0]       old_mag;
	logic                     out_free;
	logic                     ring_wr;

	assign pop_ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || results.ready;
	assign ring_wr   = (state_q == S_PUSH) && (item_q.cls != ITEM_FIRST);

	always_comb begin
		trial    = {rem_q, low_q[RSI_W-1]};
		ge       = (trial >= {1'b0, den_q});
		// oldest slot of the window: slot - win, wrapped into the ring
		old_wide = (WW + 1)'(slot_q) + (WW + 1)'(WINDOW_MAX) - (WW + 1)'(win);
		old_addr = (old_wide >= (WW + 1)'(WINDOW_MAX)) ?
			AW'(old_wide - (WW + 1)'(WINDOW_MAX)) : AW'(old_wide);
		lim      = $signed({1'b0, cfg.limit});
		neg_lim  = -lim;
		rsi_v    = (loss_q == '0) ? RSI_FULL : quo_q;
		buy_ok   = (rsi_v < cfg.oversold) && (pos_q < lim);
		sell_ok  = (rsi_q > cfg.overbought) && (pos_q > neg_lim);
		cash_ext = {cash_q[CASH_W-1], cash_q};
		price_ext = {{(CASH_W + 1 - PRICE_W){1'b0}}, item_q.price};
		prod_ext = {{(CASH_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
		new_mag  = mag(item_q.diff);
		old_mag  = mag(old_q);
	end

	// difference ring, one write and one registered read
	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring_mem[slot_q] <= item_q.diff;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BUY) begin
			old_q <= ring_mem[old_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			pos_q       <= '0;
			cash_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// S_OUT reloads the output register itself
			if (out_valid_q && results.ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				slot_q <= '0;
				gain_q <= '0;
				loss_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						item_q  <= pop_entry;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					rsi_q  <= '0;
					kind_q <= ORDER_NONE;
					if (item_q.cls != ITEM_FIRST) begin
						slot_q <= (slot_q == AW'(WINDOW_MAX - 1)) ? '0 : slot_q + 1'b1;
						if (item_q.diff[DIFF_W-1]) begin
							loss_q <= loss_q + SUM_W'(new_mag);
						end else begin
							gain_q <= gain_q + SUM_W'(new_mag);
						end
					end
					state_q <= (item_q.cls == ITEM_TRADE) ? S_SCALE : S_MARK;
				end
				S_SCALE: begin
					num_q   <= NUM_W'(gain_q) * NUM_W'(RSI_FULL);
					den_q   <= DEN_W'(gain_q) + DEN_W'(loss_q);
					state_q <= S_DIVINIT;
				end
				S_DIVINIT: begin
					// quotient stays below 2^RSI_W, so the top bits start below the divisor
					rem_q   <= DEN_W'(num_q[NUM_W-1:RSI_W]);
					low_q   <= num_q[RSI_W-1:0];
					quo_q   <= '0;
					step_q  <= STEP_W'(RSI_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
					low_q  <= {low_q[RSI_W-2:0], 1'b0};
					quo_q  <= {quo_q[RSI_W-2:0], ge};
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= S_BUY;
					end
				end
				S_BUY: begin
					rsi_q <= rsi_v;
					if (buy_ok) begin
						pos_q  <= pos_q + 1'b1;
						cash_q <= sat_cash(cash_ext - price_ext);
						kind_q <= ORDER_BUY;
					end
					state_q <= S_SELL;
				end
				S_SELL: begin
					if (sell_ok) begin
						pos_q  <= pos_q - 1'b1;
						cash_q <= sat_cash(cash_ext + price_ext);
						kind_q <= (kind_q == ORDER_BUY) ? ORDER_BOTH : ORDER_SELL;
					end
					state_q <= S_MARK;
				end
				S_MARK: begin
					prod_q <= pos_q * $signed({1'b0, item_q.price});
					if (item_q.cls == ITEM_TRADE) begin
						if (old_q[DIFF_W-1]) begin
							loss_q <= loss_q - SUM_W'(old_mag);
						end else begin
							gain_q <= gain_q - SUM_W'(old_mag);
						end
					end
					state_q <= S_SAT;
				end
				S_SAT: begin
					mark_q  <= sat_cash(cash_ext + prod_ext);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_active_q <= (item_q.cls == ITEM_TRADE);
						out_rsi_q    <= rsi_q;
						out_kind_q   <= kind_q;
						out_pos_q    <= pos_q;
						out_cash_q   <= cash_q;
						out_mark_q   <= mark_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.active         = out_active_q;
	assign results.rsi_hundredths = out_rsi_q;
	assign results.order_kind     = out_kind_q;
	assign results.net_position   = out_pos_q;
	assign results.cash_cents     = $signed(out_cash_q);
	assign results.marked_value   = $signed(out_mark_q);

endmodule
`default_nettype wire

/* rtl/rsi_threshold_trader.sv */
// Channel   Dir  Transfer when        Payload
// prices    in   valid && ready       price_cents (u32, cents)
// results   out  valid && ready       active, rsi_hundredths, order_kind,
//                                     net_position, cash_cents, marked_value
// cfg       in   cfg_wr_en            cfg_index (register), cfg_data
//
// Each trading item runs the 14-step restoring divider for RSI, priming items
// skip it; the back takes no new item until its last result is registered.
// Reset (arst_n low, async) clears all control state, the totals and the position.
// The front takes prices into a two-entry queue, so up to two transfers are
// taken while the back is busy or its result waits for results.ready.
// The difference ring needs no clearing: trades only read slots already written.
`default_nettype none
`include "assert_macros.svh"
module rsi_threshold_trader #(
	parameter int unsigned WINDOW_MAX = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [rtt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rtt_pkg::CFG_W-1:0]       cfg_data,
	rtt_price_if.sink                            prices,
	rtt_result_if.source                         results
);
	import rtt_pkg::*;

	localparam int unsigned WW    = $clog2(WINDOW_MAX + 1);
	// compare width wide enough for both the register and the window limit
	localparam int unsigned CMP_W = (WW > WLEN_W) ? WW : WLEN_W;

	logic [WLEN_W-1:0]  window_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [RSI_W-1:0]   oversold_q;
	logic [RSI_W-1:0]   overbought_q;

	logic               restart;
	logic [WW-1:0]      win;
	trade_cfg_t         trade_cfg;
	queue_entry_t       push_entry;
	queue_entry_t       pop_entry;
	logic               push_valid;
	logic               push_ready;
	logic               pop_valid;
	logic               pop_ready;

	// a window write restarts priming in both halves
	assign restart = cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_WINDOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WINDOW_RESET;
			limit_q      <= LIMIT_RESET;
			oversold_q   <= OVERSOLD_RESET;
			overbought_q <= OVERBOUGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW:     window_q     <= cfg_data[WLEN_W-1:0];
				REG_LIMIT:      limit_q      <= cfg_data[LIMIT_W-1:0];
				REG_OVERSOLD:   oversold_q   <= cfg_data[RSI_W-1:0];
				REG_OVERBOUGHT: overbought_q <= cfg_data[RSI_W-1:0];
			endcase
		end
	end

	// effective window: zero acts as one, anything above the ring depth is clipped
	always_comb begin
		priority if (window_q == '0) begin
			win = WW'(1);
		end else if (CMP_W'(window_q) > CMP_W'(WINDOW_MAX)) begin
			win = WW'(WINDOW_MAX);
		end else begin
			win = WW'(window_q);
		end
		trade_cfg.limit      = limit_q;
		trade_cfg.oversold   = oversold_q;
		trade_cfg.overbought = overbought_q;
	end

	// front: differences against the last price and classifies the item
	rtt_front #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.prices     (prices),
		.restart    (restart),
		.win        (win),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	rtt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// back: ring, running totals, divider, trade decision and book-keeping
	rtt_back #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (restart),
		.win       (win),
		.cfg       (trade_cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.results   (results)
	);

	// inactive results carry no RSI and no order
	`ASSERT_IMPLIES(a_inactive_quiet, clk, arst_n, results.valid && !results.active, (results.order_kind == ORDER_NONE) && (results.rsi_hundredths == '0), "inactive result carries an order or RSI")
	// a buy needs RSI under the oversold level
	`ASSERT_IMPLIES(a_buy_level, clk, arst_n, results.valid && (results.order_kind == ORDER_BUY || results.order_kind == ORDER_BOTH), results.rsi_hundredths < oversold_q, "buy with RSI not under oversold level")
	// a sell needs RSI over the overbought level
	`ASSERT_IMPLIES(a_sell_level, clk, arst_n, results.valid && (results.order_kind == ORDER_SELL || results.order_kind == ORDER_BOTH), results.rsi_hundredths > overbought_q, "sell with RSI not over overbought level")
	// RSI never exceeds full scale
	`ASSERT_NEVER(a_rsi_range, clk, arst_n, results.valid && (results.rsi_hundredths > RSI_FULL), "RSI above full scale")

endmodule
`default_nettype wire

/* test/rsi_threshold_trader_tb.sv */
`timescale 1ns / 100ps

module rsi_threshold_trader_tb;
	import rtt_pkg::*;

	localparam int unsigned WIN_CAP      = 256;	// ring depth, matches the instance below
	localparam int unsigned RANDOM_ITEMS = 400;	// random price ticks before wrapping up
	localparam int unsigned BIG_PHASE    = 2;	// which random phase runs a full-depth window
	localparam int unsigned SETTLE_CYCLES = 30;	// a bit over one trading item through the divider
	localparam int unsigned QUIET_LIMIT  = 4000;	// cycles with no transfer before giving up

	// one result as the block should present it
	typedef struct {
		logic                     active;
		logic [RSI_W-1:0]         rsi;
		order_kind_t              kind;
		logic signed [POS_W-1:0]  position;
		logic signed [CASH_W-1:0] cash;
		logic signed [CASH_W-1:0] marked;
	} trade_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	rtt_price_if  price_ch ();
	rtt_result_if result_ch ();

	rsi_threshold_trader #(
		.WINDOW_MAX(WIN_CAP)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.prices   (price_ch),
		.results  (result_ch)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Trader model: register copies and the strategy state
	// ------------------------------------------------------------------
	logic [WLEN_W-1:0]  cfg_window;
	logic [LIMIT_W-1:0] cfg_limit;
	logic [RSI_W-1:0]   cfg_oversold;
	logic [RSI_W-1:0]   cfg_overbought;

	logic [PRICE_W-1:0] prev_price;
	longint             diff_hist [WIN_CAP];	// signed price steps, oldest retired on trades
	int unsigned        hist_slot;
	int unsigned        prime_count;	// 0 until the first price has been seen
	logic [63:0]        gain_sum;
	logic [63:0]        loss_sum;
	longint             units_held;
	longint             cash_held;

	trade_result_t expected_trades [$];
	int            error_count = 0;

	// stimulus shaping
	bit                 calm = 1'b0;	// no idling on either side while set
	logic [PRICE_W-1:0] walk_price = 32'd500000;
	int unsigned        walk_span  = 2000;
	int unsigned        rise_odds  = 50;	// percent of steps that go up

	function automatic void reset_model();
		cfg_window     = WINDOW_RESET;
		cfg_limit      = LIMIT_RESET;
		cfg_oversold   = OVERSOLD_RESET;
		cfg_overbought = OVERBOUGHT_RESET;
		prev_price     = '0;
		foreach (diff_hist[i]) diff_hist[i] = 0;
		hist_slot   = 0;
		prime_count = 0;
		gain_sum    = '0;
		loss_sum    = '0;
		units_held  = 0;
		cash_held   = 0;
	endfunction

	// signed 64-bit add that sticks at the rails
	function automatic longint clip_add(input longint a, input longint b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s[64] != s[63])
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	// add a step to the gain or loss total, or take it back out
	function automatic void tally_diff(input longint d, input bit retire);
		logic [63:0] mag;
		mag = (d < 0) ? -d : d;
		if (d > 0)
			gain_sum = retire ? gain_sum - mag : gain_sum + mag;
		else if (d < 0)
			loss_sum = retire ? loss_sum - mag : loss_sum + mag;
	endfunction

	function automatic void apply_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		case (which)
			REG_WINDOW: begin
				// a new window length starts priming over, prices and book carry on
				cfg_window  = value[WLEN_W-1:0];
				prime_count = 0;
				hist_slot   = 0;
				gain_sum    = '0;
				loss_sum    = '0;
			end
			REG_LIMIT:      cfg_limit      = value[LIMIT_W-1:0];
			REG_OVERSOLD:   cfg_oversold   = value[RSI_W-1:0];
			REG_OVERBOUGHT: cfg_overbought = value[RSI_W-1:0];
			default: ;
		endcase
	endfunction

	// what one price tick does to the book, and what the block reports for it
	function automatic trade_result_t predict_trade(input logic [PRICE_W-1:0] price);
		trade_result_t r;
		int unsigned   win;
		int unsigned   oldest;
		longint        px;
		longint        d;
		longint        lim;
		logic [63:0]   q;
		logic [1:0]    k;

		r.active = 1'b0;
		r.rsi    = '0;
		k        = 2'b00;
		// zero acts as one, anything past the ring depth as the full ring
		win = (cfg_window == 0) ? 1 : ((cfg_window > WIN_CAP) ? WIN_CAP : cfg_window);
		px  = longint'({32'b0, price});

		if (prime_count == 0) begin
			prime_count = 1;	// nothing to difference against yet
		end else begin
			d = px - longint'({32'b0, prev_price});
			diff_hist[hist_slot] = d;
			hist_slot = (hist_slot + 1) % WIN_CAP;
			tally_diff(d, 1'b0);
			if (prime_count < win) begin
				prime_count++;
			end else begin
				r.active = 1'b1;
				lim = cfg_limit;
				// no losses at all reads as full strength, flat windows included
				if (loss_sum == 0)
					q = PCT_SCALE * PCT_SCALE;
				else
					q = (gain_sum * (PCT_SCALE * PCT_SCALE)) / (gain_sum + loss_sum);
				r.rsi = q[RSI_W-1:0];
				// buy first, then the sell sees the updated position
				if (q < cfg_oversold && units_held < lim) begin
					units_held++;
					cash_held = clip_add(cash_held, -px);
					k[0] = 1'b1;
				end
				if (q > cfg_overbought && units_held > -lim) begin
					units_held--;
					cash_held = clip_add(cash_held, px);
					k[1] = 1'b1;
				end
				oldest = (hist_slot + WIN_CAP - win) % WIN_CAP;
				tally_diff(diff_hist[oldest], 1'b1);
			end
		end
		prev_price = price;

		r.kind     = order_kind_t'(k);
		r.position = units_held[POS_W-1:0];
		r.cash     = cash_held;
		r.marked   = clip_add(cash_held, units_held * px);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Idling, mismatch reporting, price walk
	// ------------------------------------------------------------------

	// mostly back to back, now and then a pause that can span a whole trading item
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want)
			report_error($sformatf("%s: expected %0d, got %0d", name, want, got));
	endtask

	// drifting walk with the odd wild tick and the odd rail value
	function automatic logic [PRICE_W-1:0] next_price();
		int unsigned pick;
		longint      step;
		longint      p;
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			walk_price = $urandom;
		end else if (pick < 9) begin
			walk_price = pick[0] ? '1 : '0;
		end else begin
			step = $urandom_range(0, walk_span);
			if ($urandom_range(0, 99) >= rise_odds) step = -step;
			p = longint'({32'b0, walk_price}) + step;
			if (p < 0) p = 0;
			else if (p > 64'sd4294967295) p = 64'sd4294967295;
			walk_price = p[PRICE_W-1:0];
		end
		return walk_price;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One price transfer. valid is left high afterwards so that a back to back
	// tick never sees valid dropped and raised in the same step.
	task automatic send_price(input logic [PRICE_W-1:0] price);
		int unsigned   gap;
		trade_result_t want;
		gap = pick_gap();
		if (gap > 0) begin
			price_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		price_ch.valid       <= 1'b1;
		price_ch.price_cents <= price;
		@(posedge clk);
		while (!price_ch.ready) @(posedge clk);
		want = predict_trade(price);
		expected_trades.insert(expected_trades.size(), want);
	endtask

	// registers are only touched with the block drained
	task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= which;
		cfg_data  <= value;
		@(posedge clk);
		apply_reg(which, value);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		price_ch.valid <= 1'b0;
		while (expected_trades.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side back-pressure
	int unsigned ready_hold = 0;
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			result_ch.ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else begin
			result_ch.ready <= 1'b1;
			ready_hold <= pick_gap();
		end
	end

	// every result transfer is matched against the oldest prediction
	always @(posedge clk) begin : check_results
		trade_result_t want;
		if (arst_n === 1'b1 && result_ch.valid && result_ch.ready) begin
			if (expected_trades.size() == 0) begin
				report_error("result transfer with no price outstanding");
			end else begin
				want = expected_trades.pop_front();
				check_field("active", want.active, result_ch.active);
				check_field("rsi_hundredths", want.rsi, result_ch.rsi_hundredths);
				check_field("order_kind", want.kind, result_ch.order_kind);
				check_field("net_position", want.position, result_ch.net_position);
				check_field("cash_cents", want.cash, result_ch.cash_cents);
				check_field("marked_value", want.marked, result_ch.marked_value);
			end
		end
	end

	// hang detection: no transfer on either channel for too long
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((price_ch.valid && price_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values only: window 14, limit 5, levels 3000/7000. A full-scale
	// rise, then a slide, so the first trade sells on strength and the next
	// buys once the big gain has left the window.
	task automatic test_defaults();
		send_price(32'h0000_0000);
		send_price(32'hFFFF_FFFF);
		for (int i = 1; i <= 14; i++)
			send_price(32'hFFFF_FFFF - i * 1000);
	endtask

	// Window written as zero behaves as one: every tick after the first
	// trades. Pure rise reads 10000, pure fall reads 0, a flat tick has no
	// loss and so also reads 10000.
	task automatic test_rsi_extremes();
		wait_idle();
		write_reg(REG_WINDOW, '0);
		send_price(32'd5000);
		send_price(32'd6000);
		send_price(32'd4000);
		send_price(32'd4000);
	endtask

	// Oversold above overbought: a buy and a sell on the same tick.
	task automatic test_both_orders();
		wait_idle();
		write_reg(REG_OVERSOLD, 16'd16383);
		write_reg(REG_OVERBOUGHT, 16'd0);
		send_price(32'd4100);
		send_price(32'd3900);
	endtask

	// Build a long position, then pull the limit under it: further buys are
	// refused and the position is left alone; then widen to the top and sell.
	task automatic test_limit_below_position();
		wait_idle();
		write_reg(REG_LIMIT, 16'd3);
		write_reg(REG_OVERBOUGHT, 16'd16383);
		for (int i = 0; i < 3; i++) send_price(32'd10000 + i * 10);
		wait_idle();
		write_reg(REG_LIMIT, 16'd1);
		for (int i = 0; i < 2; i++) send_price(32'd10100 + i * 10);
		wait_idle();
		write_reg(REG_LIMIT, 16'd65535);
		write_reg(REG_OVERSOLD, 16'd0);
		write_reg(REG_OVERBOUGHT, 16'd0);
		for (int i = 0; i < 2; i++) send_price(32'd10200 + i * 10);
	endtask

	// Phases of random settings and price walks. Most phases use short
	// windows so trades come quickly; one runs the deepest window the ring
	// allows. Some phases keep the window so the difference history carries across.
	task automatic test_random_phases();
		int unsigned sent;
		int unsigned phase;
		int unsigned count;
		int unsigned r;
		logic [CFG_W-1:0] v;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			calm = ($urandom_range(0, 4) == 0);

			if (phase == BIG_PHASE || $urandom_range(0, 3) != 0) begin
				if (phase == BIG_PHASE)
					v = 16'($urandom_range(WIN_CAP, 511));
				else if ($urandom_range(0, 9) == 0)
					v = '0;
				else
					v = 16'($urandom_range(1, 16));
				// bits above the register width should be dropped
				if ($urandom_range(0, 3) == 0)
					v[CFG_W-1:WLEN_W] = (CFG_W - WLEN_W)'($urandom);
				write_reg(REG_WINDOW, v);
			end

			r = $urandom_range(0, 99);
			v = (r < 15) ? 16'd0 : (r < 25) ? 16'd65535 : 16'($urandom_range(1, 6));
			write_reg(REG_LIMIT, v);

			r = $urandom_range(0, 99);
			v = (r < 10) ? 16'd0 : (r < 20) ? 16'd10000 :
				(r < 25) ? 16'($urandom_range(10001, 16383)) : 16'($urandom_range(2000, 5000));
			write_reg(REG_OVERSOLD, v);

			r = $urandom_range(0, 99);
			v = (r < 10) ? 16'd0 : (r < 20) ? 16'd10000 :
				(r < 25) ? 16'($urandom_range(10001, 16383)) : 16'($urandom_range(5000, 8000));
			write_reg(REG_OVERBOUGHT, v);

			// a trend per phase pushes RSI towards one end or the other
			rise_odds = $urandom_range(15, 85);
			walk_span = ($urandom_range(0, 3) == 0) ? 2000000 : 2000;
			count = (phase == BIG_PHASE) ? 270 : $urandom_range(12, 30);
			repeat (count) send_price(next_price());
			sent += count;
			phase++;
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_index            <= REG_WINDOW;
		cfg_data             <= '0;
		price_ch.valid       <= 1'b0;
		price_ch.price_cents <= '0;
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_rsi_extremes();
		test_both_orders();
		test_limit_below_position();
		test_random_phases();

		// drain, then let any stray result show itself
		wait_idle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
